FILE: src/occ_pkg.sv
package occ_pkg;

   localparam int FIELD_BITS = 16;
   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;

   typedef logic signed [FIELD_BITS-1:0] field_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef enum logic [1:0] {
      SGN_ZERO,
      SGN_POS,
      SGN_NEG
   } sign_type;

   // low COORD_BITS of the field; a narrower field is zero-extended
   function automatic coord_type to_coord(field_type f);
      logic [FIELD_BITS-1:0] u;
      u = $unsigned(f);
      return coord_type'(u);
   endfunction

   function automatic diff_type coord_sub(coord_type a, coord_type b);
      return diff_type'(a) - diff_type'(b);
   endfunction

   // sign of a - b, computed one bit wider than the products
   function automatic sign_type diff_sign(prod_type a, prod_type b);
      logic signed [PROD_BITS:0] d;
      sign_type s;
      d = {a[PROD_BITS-1], a} - {b[PROD_BITS-1], b};
      if (d == '0) begin
         s = SGN_ZERO;
      end else if (d[PROD_BITS]) begin
         s = SGN_NEG;
      end else begin
         s = SGN_POS;
      end
      return s;
   endfunction

   function automatic logic in_box(point_type a, point_type b, point_type r);
      coord_type xlo, xhi, ylo, yhi;
      xlo = (a.x < b.x) ? a.x : b.x;
      xhi = (a.x < b.x) ? b.x : a.x;
      ylo = (a.y < b.y) ? a.y : b.y;
      yhi = (a.y < b.y) ? b.y : a.y;
      return (r.x >= xlo) && (r.x <= xhi) && (r.y >= ylo) && (r.y <= yhi);
   endfunction

   function automatic logic opposite(sign_type a, sign_type b);
      return (a == SGN_POS && b == SGN_NEG) || (a == SGN_NEG && b == SGN_POS);
   endfunction

endpackage

FILE: src/occ_orient_prod.sv
module occ_orient_prod (
   input  occ_pkg::point_type p,
   input  occ_pkg::point_type q,
   input  occ_pkg::point_type r,
   output occ_pkg::prod_type  lhs_prod,
   output occ_pkg::prod_type  rhs_prod
);
   import occ_pkg::*;

   // orient(p, q, r) = (qy - py) * (rx - qx) - (qx - px) * (ry - qy)
   diff_type dqy, drx, dqx, dry;

   always_comb begin
      dqy      = coord_sub(q.y, p.y);
      drx      = coord_sub(r.x, q.x);
      dqx      = coord_sub(q.x, p.x);
      dry      = coord_sub(r.y, q.y);
      lhs_prod = prod_type'(dqy) * prod_type'(drx);
      rhs_prod = prod_type'(dqx) * prod_type'(dry);
   end

endmodule

FILE: src/segment_polygon_occlusion_test.sv
// Streams obstacle edges against a query segment and reports, for every edge
// item, whether the segment is blocked by any edge of the query so far;
// rsp_query_done marks the final answer and the running hit flag clears after
// it. Edges that share an exact endpoint with the segment are skipped. One item
// is taken every cycle while req_stall is low; each item passes an input
// register and the result register, with the four orientation cross products
// (17x17 signed multipliers) and the hit decision formed between them.
// req_stall rises only while both registers hold items and rsp_stall is high.
module segment_polygon_occlusion_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  occ_pkg::field_type req_seg_start_x,
   input  occ_pkg::field_type req_seg_start_y,
   input  occ_pkg::field_type req_seg_end_x,
   input  occ_pkg::field_type req_seg_end_y,
   input  occ_pkg::field_type req_edge_a_x,
   input  occ_pkg::field_type req_edge_a_y,
   input  occ_pkg::field_type req_edge_b_x,
   input  occ_pkg::field_type req_edge_b_y,
   input  logic               req_last_edge,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_blocked,
   output logic               rsp_query_done
);
   import occ_pkg::*;

   logic adv0, adv1;

   // input register
   logic      s0_valid_ff, s0_valid_in;
   point_type s0_p_ff, s0_q_ff, s0_a_ff, s0_b_ff;
   logic      s0_last_ff;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_blocked_ff, rsp_blocked_in;
   logic      rsp_done_ff;
   logic      hit_accum_ff, hit_accum_in;

   prod_type  l1, r1, l2, r2, l3, r3, l4, r4;
   sign_type  d1, d2, d3, d4;
   logic      shared, hit;

   assign adv1 = !rsp_valid_ff || !rsp_stall;
   assign adv0 = !s0_valid_ff || adv1;
   assign req_stall = !adv0;

   assign s0_valid_in  = adv0 ? req_valid   : s0_valid_ff;
   assign rsp_valid_in = adv1 ? s0_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_accum_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_accum_ff <= hit_accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         s0_p_ff    <= '{x: to_coord(req_seg_start_x), y: to_coord(req_seg_start_y)};
         s0_q_ff    <= '{x: to_coord(req_seg_end_x),   y: to_coord(req_seg_end_y)};
         s0_a_ff    <= '{x: to_coord(req_edge_a_x),    y: to_coord(req_edge_a_y)};
         s0_b_ff    <= '{x: to_coord(req_edge_b_x),    y: to_coord(req_edge_b_y)};
         s0_last_ff <= req_last_edge;
      end
   end

   assign shared = (s0_p_ff == s0_a_ff) || (s0_p_ff == s0_b_ff) ||
                   (s0_q_ff == s0_a_ff) || (s0_q_ff == s0_b_ff);

   occ_orient_prod u_orient1 (
      .p(s0_p_ff), .q(s0_q_ff), .r(s0_a_ff), .lhs_prod(l1), .rhs_prod(r1)
   );
   occ_orient_prod u_orient2 (
      .p(s0_p_ff), .q(s0_q_ff), .r(s0_b_ff), .lhs_prod(l2), .rhs_prod(r2)
   );
   occ_orient_prod u_orient3 (
      .p(s0_a_ff), .q(s0_b_ff), .r(s0_p_ff), .lhs_prod(l3), .rhs_prod(r3)
   );
   occ_orient_prod u_orient4 (
      .p(s0_a_ff), .q(s0_b_ff), .r(s0_q_ff), .lhs_prod(l4), .rhs_prod(r4)
   );

   always_comb begin
      d1  = diff_sign(l1, r1);
      d2  = diff_sign(l2, r2);
      d3  = diff_sign(l3, r3);
      d4  = diff_sign(l4, r4);
      hit = !shared &&
            ((opposite(d1, d2) && opposite(d3, d4)) ||
             (d1 == SGN_ZERO && in_box(s0_p_ff, s0_q_ff, s0_a_ff)) ||
             (d2 == SGN_ZERO && in_box(s0_p_ff, s0_q_ff, s0_b_ff)) ||
             (d3 == SGN_ZERO && in_box(s0_a_ff, s0_b_ff, s0_p_ff)) ||
             (d4 == SGN_ZERO && in_box(s0_a_ff, s0_b_ff, s0_q_ff)));
      rsp_blocked_in = hit_accum_ff || hit;
      hit_accum_in   = hit_accum_ff;
      if (adv1 && s0_valid_ff) begin
         hit_accum_in = s0_last_ff ? 1'b0 : rsp_blocked_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         rsp_blocked_ff <= rsp_blocked_in;
         rsp_done_ff    <= s0_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blocked    = rsp_blocked_ff;
   assign rsp_query_done = rsp_done_ff;

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && s0_valid_ff))
      else $error("input stalled with room in the pipeline");

   a_accum_tracks_open_query : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_query_done) |-> (hit_accum_ff == rsp_blocked))
      else $error("hit accumulator differs from last result of open query");

   a_accum_clear_after_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_query_done) |-> !hit_accum_ff)
      else $error("hit accumulator not cleared after final edge");

   a_accum_hold_when_idle : assert property (@(posedge clock) disable iff (reset)
      !(adv1 && s0_valid_ff) |=> $stable(hit_accum_ff))
      else $error("hit accumulator changed without an item");

endmodule
